FILE: design/tami_pkg.sv
// ----------------------------------------------------------------------------
// tami_pkg
// Shared types and constants for the two-axis motion interlock.
// ----------------------------------------------------------------------------
package tami_pkg;

  // field widths
  localparam int unsigned VelW    = 16;
  localparam int unsigned SwW     = 21;
  localparam int unsigned PosW    = 32;
  localparam int unsigned ActW    = 2;
  localparam int unsigned SpeedW  = 14;
  localparam int unsigned LimW    = 16;
  localparam int unsigned MagW    = 11;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  // action codes
  localparam logic [ActW-1:0] ACT_MOVE  = 2'd0;
  localparam logic [ActW-1:0] ACT_DECEL = 2'd1;
  localparam logic [ActW-1:0] ACT_ESTOP = 2'd2;

  // register indexes
  localparam logic [CfgAddrW-1:0] REG_POS_DIR     = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_PROTECTED   = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_HOMED       = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_SHOULDER_HI = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_ELBOW_HI    = 3'd4;

  // register reset values
  localparam logic [LimW-1:0] SHOULDER_HI_RST = 16'd6667;
  localparam logic [LimW-1:0] ELBOW_HI_RST    = 16'd5556;

  // soft limits at the low end, in encoder counts
  localparam logic signed [PosW-1:0] LOW_PROTECTED = 32'sd444;
  localparam logic signed [PosW-1:0] LOW_HOMED     = 32'sd555;

  // speed clamp (5 deg/s in 1/256 deg/s) and the 125/18 scale
  // as a fixed-point reciprocal: floor(m*125/18) == (m*455112) >> 16 for m < 4096
  localparam logic [MagW-1:0] SPEED_CLAMP = 11'd1280;
  localparam int unsigned     ScaleShift  = 16;
  localparam int unsigned     ScaleW      = 19;
  localparam logic [ScaleW-1:0] SPEED_SCALE = 19'd455112;
  localparam int unsigned     ProdW       = MagW + ScaleW;

  // switch word bit positions
  localparam int unsigned SW_E_MLIM  = 8;
  localparam int unsigned SW_E_MZERO = 9;
  localparam int unsigned SW_S_MLIM  = 10;
  localparam int unsigned SW_S_MZERO = 11;
  localparam int unsigned SW_E_OZERO = 16;
  localparam int unsigned SW_E_OLIM  = 17;
  localparam int unsigned SW_S_OZERO = 18;
  localparam int unsigned SW_S_OLIM  = 19;
  localparam int unsigned SW_ESTOP   = 20;

  typedef struct packed {
    logic            pos_dir;
    logic            protected_mode;
    logic            homed;
    logic [LimW-1:0] shoulder_hi;
    logic [LimW-1:0] elbow_hi;
  } tami_cfg_t;

  typedef struct packed {
    logic                   joint;
    logic signed [VelW-1:0] velocity;
    logic [SwW-1:0]         switch_word;
    logic signed [PosW-1:0] position;
  } tami_cmd_t;

  typedef struct packed {
    logic [ActW-1:0]   action;
    logic              direction_code;
    logic [SpeedW-1:0] speed;
    logic              home_reached;
    logic              estop_input;
  } tami_res_t;

endpackage

FILE: design/two_axis_motion_interlock_top.sv
// ----------------------------------------------------------------------------
// two_axis_motion_interlock_top
// Per-command safety interlock for the shoulder and elbow joints.
// ----------------------------------------------------------------------------
// pipeline: input register, then result register, from input beat to result beat
// throughput: 1 command per cycle while the result side is not stalled; the decision path holds one 11x19 multiply
// stalls on the result side back up through both registers in the same cycle
// reset: rst (synchronous) empties both stages and restores register defaults
module two_axis_motion_interlock_top import tami_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // command stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // velocity[15:0], switch_word[36:16], position_counts[68:37]
  input  logic                s_axis_tuser,  // joint
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // direction_code[0], speed[14:1], home_reached[15], estop_input[16]
  output logic [ActW-1:0]     m_axis_tuser,  // action
  // configuration writes
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  tami_cfg_t cfg;
  tami_cmd_t cmd;
  tami_res_t res_next;
  tami_res_t res;
  logic      cmd_valid;
  logic      res_valid;
  logic      adv_res;
  logic      adv_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_dir        <= 1'b0;
      cfg.protected_mode <= 1'b1;
      cfg.homed          <= 1'b0;
      cfg.shoulder_hi    <= SHOULDER_HI_RST;
      cfg.elbow_hi       <= ELBOW_HI_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_POS_DIR:     cfg.pos_dir        <= cfg_wdata[0];
        REG_PROTECTED:   cfg.protected_mode <= cfg_wdata[0];
        REG_HOMED:       cfg.homed          <= cfg_wdata[0];
        REG_SHOULDER_HI: cfg.shoulder_hi    <= cfg_wdata[LimW-1:0];
        REG_ELBOW_HI:    cfg.elbow_hi       <= cfg_wdata[LimW-1:0];
        default: ;
      endcase
    end
  end

  // stage handshakes
  assign adv_res       = !res_valid || m_axis_tready;
  assign adv_cmd       = !cmd_valid || adv_res;
  assign s_axis_tready = adv_cmd;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (adv_cmd) begin
      cmd_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_cmd && s_axis_tvalid) begin
      cmd.joint       <= s_axis_tuser;
      cmd.velocity    <= s_axis_tdata[15:0];
      cmd.switch_word <= s_axis_tdata[36:16];
      cmd.position    <= s_axis_tdata[68:37];
    end
  end

  // decision logic
  tami_decide u_decide (
    .cfg (cfg),
    .cmd (cmd),
    .res (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv_res) begin
      res_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_res && cmd_valid) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser  = res.action;
  assign m_axis_tdata  = {{(OutDataW-SpeedW-3){1'b0}}, res.estop_input, res.home_reached,
                          res.speed, res.direction_code};

endmodule

FILE: design/tami_decide.sv
// ----------------------------------------------------------------------------
// tami_decide
// Safety decision for one joint command: switch check, soft limits, speed.
// ----------------------------------------------------------------------------
module tami_decide import tami_pkg::*; (
  input  tami_cfg_t cfg,
  input  tami_cmd_t cmd,
  output tami_res_t res
);

  logic ozero_n, olim_n, mzero, mlim;
  logic pos_vel, neg_vel, safe, stop;
  logic signed [VelW:0]   vel_ext;
  logic [VelW:0]          vel_abs;
  logic [MagW-1:0]        mag;
  logic [ProdW-1:0]       prod;
  logic signed [PosW-1:0] high;
  logic                   e_oz, s_oz, e_mz, s_mz;

  // switches of the commanded joint (opto bits read low when triggered)
  assign ozero_n = cmd.joint ? cmd.switch_word[SW_E_OZERO] : cmd.switch_word[SW_S_OZERO];
  assign olim_n  = cmd.joint ? cmd.switch_word[SW_E_OLIM]  : cmd.switch_word[SW_S_OLIM];
  assign mzero   = cmd.joint ? cmd.switch_word[SW_E_MZERO] : cmd.switch_word[SW_S_MZERO];
  assign mlim    = cmd.joint ? cmd.switch_word[SW_E_MLIM]  : cmd.switch_word[SW_S_MLIM];

  assign pos_vel = !cmd.velocity[VelW-1] && (cmd.velocity != '0);
  assign neg_vel = cmd.velocity[VelW-1];

  // switch check: idle switches, or moving away from the active one
  always_comb begin
    if (ozero_n && olim_n && !mzero && !mlim) begin
      safe = 1'b1;
    end else if ((!ozero_n || mzero) && pos_vel) begin
      safe = 1'b1;
    end else if ((!olim_n || mlim) && neg_vel) begin
      safe = 1'b1;
    end else begin
      safe = 1'b0;
    end
  end

  // soft angle limits
  assign high = $signed({{(PosW-LimW){1'b0}}, (cmd.joint ? cfg.elbow_hi : cfg.shoulder_hi)});

  always_comb begin
    if (cfg.protected_mode) begin
      stop = ((cmd.position <= LOW_PROTECTED) && neg_vel) ||
             ((cmd.position >= high) && pos_vel);
    end else begin
      stop = cfg.homed && (cmd.position <= LOW_HOMED) && neg_vel;
    end
  end

  // magnitude, clamp and scale to pulse units
  assign vel_ext = {cmd.velocity[VelW-1], cmd.velocity};
  assign vel_abs = vel_ext[VelW] ? (VelW+1)'(-vel_ext) : vel_ext;
  assign mag     = (vel_abs > {{(VelW+1-MagW){1'b0}}, SPEED_CLAMP}) ? SPEED_CLAMP
                                                                  : vel_abs[MagW-1:0];
  assign prod    = {{ScaleW{1'b0}}, mag} * {{MagW{1'b0}}, SPEED_SCALE};

  // home flags
  assign e_oz = !cmd.switch_word[SW_E_OZERO];
  assign s_oz = !cmd.switch_word[SW_S_OZERO];
  assign e_mz = cmd.switch_word[SW_E_MZERO];
  assign s_mz = cmd.switch_word[SW_S_MZERO];

  // result assembly
  always_comb begin
    res.action         = ACT_MOVE;
    res.direction_code = 1'b0;
    res.speed          = '0;
    if (!safe) begin
      res.action = ACT_ESTOP;
    end else if (stop) begin
      res.action = ACT_DECEL;
    end else begin
      res.speed          = prod[ScaleShift +: SpeedW];
      res.direction_code = pos_vel ? cfg.pos_dir : !cfg.pos_dir;
    end
    res.home_reached = (e_oz && s_oz) || (s_mz && e_mz) || (e_oz && s_mz) || (s_oz && e_mz);
    res.estop_input  = cmd.switch_word[SW_ESTOP];
  end

endmodule

FILE: design/tami_checker.sv
// ----------------------------------------------------------------------------
// tami_checker
// Port-level checks on the interlock result stream.
// ----------------------------------------------------------------------------
module tami_checker import tami_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [ActW-1:0]     m_axis_tuser
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // stops carry no direction and no speed
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ACT_ESTOP || m_axis_tuser == ACT_DECEL) |->
      m_axis_tdata[SpeedW:0] == '0)
    else $error("stop beat with nonzero direction or speed");

  // speed never passes the 5 deg/s clamp
  a_speed_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[SpeedW:1] <= 14'd8888)
    else $error("speed above clamp");

  // no result in the first cycle out of reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind two_axis_motion_interlock_top tami_checker u_tami_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/tami_decision_checker.sv
// ----------------------------------------------------------------------------
// tami_decision_checker
// Watches the command, result and register-write ports of the two-axis
// motion interlock, predicts the decision for every accepted command beat
// and compares each result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tami_decision_checker import tami_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // velocity, switch_word, position_counts
  input  logic                s_axis_tuser,  // joint
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,  // direction_code, speed, home_reached, estop_input
  input  logic [ActW-1:0]     m_axis_tuser,  // action
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int unsigned         decisions_pending,
  output int unsigned         mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // soft limit thresholds and speed scaling, in encoder counts and 1/256 deg/s
  localparam int LowStopProtected = 444;
  localparam int LowStopHomed     = 555;
  localparam int VelocityClamp    = 1280;
  localparam int PulseNum         = 125;
  localparam int PulseDen         = 18;

  tami_cfg_t shadow_cfg;
  tami_cmd_t cmd_seen;
  tami_res_t got_decision;
  tami_res_t want_decision;
  tami_res_t expected_decisions[$];

  // decision for one command under the given register settings
  function automatic tami_res_t interlock_decision(tami_cfg_t c, tami_cmd_t cmd);
    tami_res_t r;
    logic [SwW-1:0] sw;
    logic opto_zero, opto_lim, mech_zero, mech_lim;
    logic fwd, rev, clear, soft_stop;
    int vel, pos, upper, mag;
    r   = '0;
    sw  = cmd.switch_word;
    vel = int'($signed(cmd.velocity));
    pos = int'($signed(cmd.position));
    if (cmd.joint) begin
      opto_zero = sw[SW_E_OZERO];
      opto_lim  = sw[SW_E_OLIM];
      mech_zero = sw[SW_E_MZERO];
      mech_lim  = sw[SW_E_MLIM];
      upper     = int'({16'd0, c.elbow_hi});
    end else begin
      opto_zero = sw[SW_S_OZERO];
      opto_lim  = sw[SW_S_OLIM];
      mech_zero = sw[SW_S_MZERO];
      mech_lim  = sw[SW_S_MLIM];
      upper     = int'({16'd0, c.shoulder_hi});
    end
    fwd = (vel > 0);
    rev = (vel < 0);
    // opto levels are active low, mechanical contacts active high
    clear = (opto_zero && opto_lim && !mech_zero && !mech_lim) ||
            ((!opto_zero || mech_zero) && fwd) ||
            ((!opto_lim || mech_lim) && rev);
    if (!clear) begin
      r.action = ACT_ESTOP;
    end else begin
      if (c.protected_mode) begin
        soft_stop = (pos <= LowStopProtected && rev) || (pos >= upper && fwd);
      end else begin
        soft_stop = c.homed && (pos <= LowStopHomed) && rev;
      end
      if (soft_stop) begin
        r.action = ACT_DECEL;
      end else begin
        mag = rev ? -vel : vel;
        if (mag > VelocityClamp) mag = VelocityClamp;
        r.action         = ACT_MOVE;
        r.speed          = SpeedW'((mag * PulseNum) / PulseDen);
        r.direction_code = fwd ? c.pos_dir : ~c.pos_dir;
      end
    end
    r.home_reached = (!sw[SW_E_OZERO] && !sw[SW_S_OZERO]) ||
                     (sw[SW_S_MZERO] && sw[SW_E_MZERO]) ||
                     (!sw[SW_E_OZERO] && sw[SW_S_MZERO]) ||
                     (!sw[SW_S_OZERO] && sw[SW_E_MZERO]);
    r.estop_input  = sw[SW_ESTOP];
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // register shadow, prediction on command beats, compare on result beats
  always @(posedge clk) begin
    if (rst) begin
      shadow_cfg.pos_dir        = 1'b0;
      shadow_cfg.protected_mode = 1'b1;
      shadow_cfg.homed          = 1'b0;
      shadow_cfg.shoulder_hi    = SHOULDER_HI_RST;
      shadow_cfg.elbow_hi       = ELBOW_HI_RST;
      expected_decisions.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_POS_DIR:     shadow_cfg.pos_dir        = cfg_wdata[0];
          REG_PROTECTED:   shadow_cfg.protected_mode = cfg_wdata[0];
          REG_HOMED:       shadow_cfg.homed          = cfg_wdata[0];
          REG_SHOULDER_HI: shadow_cfg.shoulder_hi    = cfg_wdata[LimW-1:0];
          REG_ELBOW_HI:    shadow_cfg.elbow_hi       = cfg_wdata[LimW-1:0];
          default: ;
        endcase
      end
      // result side first so a stray beat never pairs with this cycle's command
      if (m_axis_tvalid && m_axis_tready) begin
        got_decision.action         = m_axis_tuser;
        got_decision.direction_code = m_axis_tdata[0];
        got_decision.speed          = m_axis_tdata[1 +: SpeedW];
        got_decision.home_reached   = m_axis_tdata[SpeedW + 1];
        got_decision.estop_input    = m_axis_tdata[SpeedW + 2];
        if (expected_decisions.size() == 0) begin
          $error("result beat with no command outstanding");
          mismatch_count++;
        end else begin
          want_decision = expected_decisions.pop_front();
          compare_field("action", want_decision.action, got_decision.action);
          compare_field("direction_code", want_decision.direction_code,
                        got_decision.direction_code);
          compare_field("speed", want_decision.speed, got_decision.speed);
          compare_field("home_reached", want_decision.home_reached,
                        got_decision.home_reached);
          compare_field("estop_input", want_decision.estop_input,
                        got_decision.estop_input);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cmd_seen.joint       = s_axis_tuser;
        cmd_seen.velocity    = s_axis_tdata[0 +: VelW];
        cmd_seen.switch_word = s_axis_tdata[VelW +: SwW];
        cmd_seen.position    = s_axis_tdata[VelW + SwW +: PosW];
        expected_decisions.push_back(interlock_decision(shadow_cfg, cmd_seen));
      end
    end
    decisions_pending = expected_decisions.size();
  end

endmodule

FILE: verif/tb_two_axis_motion_interlock_top.sv
// ----------------------------------------------------------------------------
// tb_two_axis_motion_interlock_top
// Drives directed and random joint commands through the interlock under
// several register settings and handshake idling patterns; the checker
// beside the block predicts every decision and counts mismatches.
// ----------------------------------------------------------------------------
module tb_two_axis_motion_interlock_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tami_pkg::*;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned TailCycles  = 10;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned PhaseItems  = 150;
  localparam int unsigned PadW        = InDataW - VelW - SwW - PosW;

  // single switch masks; opto inputs idle high
  localparam logic [SwW-1:0] M_E_MLIM  = SwW'(1) << SW_E_MLIM;
  localparam logic [SwW-1:0] M_E_MZERO = SwW'(1) << SW_E_MZERO;
  localparam logic [SwW-1:0] M_S_MLIM  = SwW'(1) << SW_S_MLIM;
  localparam logic [SwW-1:0] M_S_MZERO = SwW'(1) << SW_S_MZERO;
  localparam logic [SwW-1:0] M_E_OZERO = SwW'(1) << SW_E_OZERO;
  localparam logic [SwW-1:0] M_E_OLIM  = SwW'(1) << SW_E_OLIM;
  localparam logic [SwW-1:0] M_S_OZERO = SwW'(1) << SW_S_OZERO;
  localparam logic [SwW-1:0] M_S_OLIM  = SwW'(1) << SW_S_OLIM;
  localparam logic [SwW-1:0] M_ESTOP   = SwW'(1) << SW_ESTOP;
  localparam logic [SwW-1:0] OPTO_RELEASED = M_E_OZERO | M_E_OLIM | M_S_OZERO | M_S_OLIM;
  localparam logic [SwW-1:0] SWITCH_BITS   = OPTO_RELEASED |
                                             M_E_MLIM | M_E_MZERO | M_S_MLIM | M_S_MZERO;

  // handshake idling patterns
  typedef enum int unsigned {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // velocity, switch_word, position_counts
  logic                s_axis_tuser  = 1'b0;  // joint
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;  // direction_code, speed, home_reached, estop_input
  logic [ActW-1:0]     m_axis_tuser;  // action
  logic                cfg_we        = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr      = '0;
  logic [CfgDataW-1:0] cfg_wdata     = '0;

  int unsigned decisions_pending;
  int unsigned mismatch_count;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  logic [LimW-1:0] shoulder_hi_now = SHOULDER_HI_RST;
  logic [LimW-1:0] elbow_hi_now    = ELBOW_HI_RST;

  two_axis_motion_interlock_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  tami_decision_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tuser      (m_axis_tuser),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .decisions_pending (decisions_pending),
    .mismatch_count    (mismatch_count)
  );

  always #1 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("two_axis_motion_interlock_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one command beat, with random sender gaps ahead of it
  task automatic send_command(input logic joint, input logic [VelW-1:0] vel,
                              input logic [SwW-1:0] sw, input logic [PosW-1:0] pos);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= joint;
    s_axis_tdata  <= {{PadW{1'b0}}, pos, sw, vel};
    @(posedge clk);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk);
  endtask

  // hold off commands until every predicted decision has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (decisions_pending != 0) @(posedge clk);
  endtask

  // write all registers, one spare index, junk in the unused data bits
  task automatic apply_settings(input logic pos_dir, input logic prot, input logic homed,
                                input logic [LimW-1:0] sh_hi, input logic [LimW-1:0] el_hi);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_POS_DIR;
    cfg_wdata <= {(CfgDataW-1)'($urandom), pos_dir};
    @(posedge clk);
    cfg_addr  <= REG_PROTECTED;
    cfg_wdata <= {(CfgDataW-1)'($urandom), prot};
    @(posedge clk);
    cfg_addr  <= REG_HOMED;
    cfg_wdata <= {(CfgDataW-1)'($urandom), homed};
    @(posedge clk);
    cfg_addr  <= REG_SHOULDER_HI;
    cfg_wdata <= sh_hi;
    @(posedge clk);
    cfg_addr  <= REG_ELBOW_HI;
    cfg_wdata <= el_hi;
    @(posedge clk);
    cfg_addr  <= CfgAddrW'($urandom_range(2 ** CfgAddrW - 1, REG_ELBOW_HI + 1));
    cfg_wdata <= CfgDataW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    shoulder_hi_now = sh_hi;
    elbow_hi_now    = el_hi;
  endtask

  // edges of the soft limits, clamp, every switch rule and home combination
  task automatic send_directed();
    send_command(1'b0, 16'sd1000, OPTO_RELEASED, 32'sd0);
    send_command(1'b0, -16'sd1000, OPTO_RELEASED, 32'sd444);
    send_command(1'b0, -16'sd1000, OPTO_RELEASED, 32'sd445);
    send_command(1'b0, 16'sh7FFF, OPTO_RELEASED, 32'sd6667);
    send_command(1'b0, 16'sh7FFF, OPTO_RELEASED, 32'sd6666);
    send_command(1'b1, 16'sh7FFF, OPTO_RELEASED, 32'sd5556);
    send_command(1'b1, 16'sh8000, OPTO_RELEASED, 32'sh7FFFFFFF);
    send_command(1'b1, -16'sd5, OPTO_RELEASED, 32'sh80000000);
    // zero velocity: move with the reverse code, or estop on any active switch
    send_command(1'b1, 16'sd0, OPTO_RELEASED, 32'sd1000);
    send_command(1'b1, 16'sd0, OPTO_RELEASED ^ M_E_OZERO, 32'sd1000);
    // zero switches allow only forward motion, limit switches only reverse
    send_command(1'b0, 16'sd1, OPTO_RELEASED ^ M_S_OZERO, 32'sd1000);
    send_command(1'b0, -16'sd1, OPTO_RELEASED ^ M_S_OZERO, 32'sd1000);
    send_command(1'b0, -16'sd1281, OPTO_RELEASED ^ M_S_OLIM, 32'sd1000);
    send_command(1'b0, 16'sd1281, OPTO_RELEASED ^ M_S_OLIM, 32'sd1000);
    send_command(1'b1, 16'sd100, OPTO_RELEASED ^ M_E_MZERO, 32'sd1000);
    send_command(1'b1, -16'sd100, OPTO_RELEASED ^ M_E_MZERO, 32'sd1000);
    send_command(1'b1, -16'sd1280, OPTO_RELEASED ^ M_E_MLIM, 32'sd1000);
    send_command(1'b1, 16'sd1280, OPTO_RELEASED ^ M_E_MLIM, 32'sd1000);
    send_command(1'b0, 16'sd300, OPTO_RELEASED ^ M_ESTOP, 32'sd2000);
    // home combinations, switches of both joints
    send_command(1'b0, 16'sd50, OPTO_RELEASED ^ M_S_OZERO ^ M_E_OZERO, 32'sd2000);
    send_command(1'b1, 16'sd50, OPTO_RELEASED ^ M_S_MZERO ^ M_E_MZERO, 32'sd2000);
    send_command(1'b0, 16'sd50, OPTO_RELEASED ^ M_E_OZERO ^ M_S_MZERO, 32'sd2000);
    send_command(1'b1, 16'sd50, OPTO_RELEASED ^ M_S_OZERO ^ M_E_MZERO, 32'sd2000);
    send_command(1'b0, -16'sd7, {SwW{1'b1}}, 32'sd2000);
    send_command(1'b1, 16'sd7, {SwW{1'b0}}, 32'sd2000);
  endtask

  // random command, mostly with switches at rest, often with positions near limits
  task automatic send_random_command();
    logic            joint;
    logic [VelW-1:0] vel;
    logic [SwW-1:0]  sw;
    logic [PosW-1:0] pos;
    int unsigned     pick;
    joint = 1'($urandom);
    pick  = $urandom_range(9);
    if (pick < 5)       vel = VelW'($urandom_range(3000) - 1500);
    else if (pick == 5) vel = '0;
    else if (pick == 6) vel = VelW'(int'($urandom_range(1290, 1270)) *
                                    ($urandom_range(1) ? 1 : -1));
    else                vel = VelW'($urandom);
    sw = SwW'($urandom);
    if ($urandom_range(99) < 60) begin
      sw = (sw & ~SWITCH_BITS) | OPTO_RELEASED;
      for (int k = SW_E_MLIM; k < SW_ESTOP; k++) begin
        if (SWITCH_BITS[k] && $urandom_range(99) < 12) sw[k] = ~sw[k];
      end
    end
    pick = $urandom_range(9);
    case (pick)
      0, 1:    pos = PosW'($urandom_range(450, 438));
      2:       pos = PosW'($urandom_range(561, 549));
      3:       pos = PosW'(int'(joint ? elbow_hi_now : shoulder_hi_now) +
                           int'($urandom_range(8)) - 4);
      4, 5, 6: pos = PosW'(int'($urandom_range(9000)) - 1000);
      default: pos = PosW'($urandom);
    endcase
    send_command(joint, vel, sw, pos);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings, back-to-back beats
    send_directed();
    drain_results();

    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: ;
        1: apply_settings(1'b1, 1'b0, 1'b0, '0, '1);
        2: apply_settings(1'b0, 1'b0, 1'b1, '1, '0);
        3: apply_settings(1'b1, 1'b1, 1'b1, LimW'($urandom_range(7000)),
                          LimW'($urandom_range(7000)));
        4: apply_settings(1'b0, 1'b1, 1'b1, '1, '0);
        5: apply_settings(1'b1, 1'b1, 1'b0, '0, '1);
        default: apply_settings(1'($urandom), 1'($urandom), 1'($urandom),
                                LimW'($urandom), LimW'($urandom_range(8000)));
      endcase
      case (idle_mode_e'(phase % 4))
        IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        IDLE_SENDER:   begin tx_idle_pct = 83; rx_stall_pct = 0;  end
        IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
        IDLE_BOTH:     begin tx_idle_pct = 9;  rx_stall_pct = 9;  end
      endcase
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        send_random_command();
        // mid-phase hold-off until the pipeline runs empty
        if (n == PhaseItems / 2 && phase == 0) drain_results();
      end
      drain_results();
    end

    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("two_axis_motion_interlock_top test passed");
    end else begin
      $display("two_axis_motion_interlock_top test failed");
    end
    $finish;
  end

endmodule
